FILE: design/tqsb_pkg.sv
`default_nettype none

package tqsb_pkg;

  // longest run of results that one list item produces
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS);
  localparam int DATA_W      = 32;

  typedef enum logic [2:0] {
    OP_INS_A = 3'd0,
    OP_INS_B = 3'd1,
    OP_REM_A = 3'd2,
    OP_REM_B = 3'd3,
    OP_LST_A = 3'd4,
    OP_LST_B = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_OUT  = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_out;
    logic                     last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       ins_a;
    logic       ins_b;
    logic       rem_a;
    logic       rem_b;
    logic       lst_a;
    logic       lst_b;
    logic       step;
    logic       load;
    logic [1:0] status;
    logic       mem;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty_a;
    logic empty_b;
    logic full;
    logic last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/two_queues_shared_buffer.sv
// Two FIFO queues in one store of DEPTH 32-bit entries: queue A fills upward
// from entry 0, queue B downward from entry DEPTH-1. Each transfer on the input
// channel carries an opcode (insert, remove or list, for A or B) and a value.
// Insert answers ok or overflow when the tails meet, remove returns the head
// entry or an empty status, list returns up to 16 entries from head to tail
// with last set on the final one; unused opcodes are dropped silently. A queue
// reuses freed slots only after it drains. Timing: the first result of an item
// appears in the cycle after its input transfer, since the store has a
// registered read port; list results then follow one per cycle through that
// same port while out_ready is high. One item is in work at a time: an item
// holds the block until its last result transfers, and the next item is taken
// in the cycle its predecessor's last result transfers. An unused opcode
// produces no result and does not hold the block.
// The store is not cleared at reset.
`default_nettype none

module two_queues_shared_buffer #(
  parameter int DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tqsb_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tqsb_pkg::out_item_t       out_data
);
  import tqsb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  tqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (in_data.opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, pointers and result register
  tqsb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value_in (in_data.value_in),
    .stat     (stat),
    .result   (out_data)
  );

  // a new item only enters while the final result of the previous one leaves
  a_handoff: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> (out_ready && out_data.last))
    else $error("input taken while results still pending");

  // refused or empty answers are single results with no data
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> (out_data.last && out_data.value_out == '0))
    else $error("error result not final or carries data");

  // both queues empty can never look full
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    (stat.empty_a && stat.empty_b) |-> !stat.full)
    else $error("empty store flagged full");

  // a list walk keeps the output valid until its last entry transfers
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("list walk lost its next result");

endmodule

`default_nettype wire

FILE: design/tqsb_ctrl.sv
`default_nettype none

module tqsb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        opcode,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire tqsb_pkg::dp_stat_t stat,
  output tqsb_pkg::dp_cmd_t      cmd
);
  import tqsb_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    take       = 1'b0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        take     = in_valid;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last) begin
            // final result leaves, next item may enter in the same cycle
            in_ready   = 1'b1;
            take       = in_valid;
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // decode an accepted item
    if (take) begin
      unique case (opcode)
        OP_INS_A, OP_INS_B: begin
          cmd.load   = 1'b1;
          cmd.status = stat.full ? ST_OVF : ST_OK;
          cmd.ins_a  = !stat.full && (opcode == OP_INS_A);
          cmd.ins_b  = !stat.full && (opcode == OP_INS_B);
          state_next = S_OUT;
        end
        OP_REM_A, OP_LST_A: begin
          cmd.load   = 1'b1;
          cmd.status = stat.empty_a ? ST_EMPTY : ST_OK;
          cmd.mem    = !stat.empty_a;
          cmd.rem_a  = !stat.empty_a && (opcode == OP_REM_A);
          cmd.lst_a  = !stat.empty_a && (opcode == OP_LST_A);
          state_next = S_OUT;
        end
        OP_REM_B, OP_LST_B: begin
          cmd.load   = 1'b1;
          cmd.status = stat.empty_b ? ST_EMPTY : ST_OK;
          cmd.mem    = !stat.empty_b;
          cmd.rem_b  = !stat.empty_b && (opcode == OP_REM_B);
          cmd.lst_b  = !stat.empty_b && (opcode == OP_LST_B);
          state_next = S_OUT;
        end
        default: begin
          // unused opcode: dropped without a result
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/tqsb_datapath.sv
`default_nettype none

module tqsb_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tqsb_pkg::dp_cmd_t                     cmd,
  input  wire logic signed [tqsb_pkg::DATA_W-1:0]    value_in,
  output tqsb_pkg::dp_stat_t                         stat,
  output tqsb_pkg::out_item_t                        result
);
  import tqsb_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  logic [IW-1:0]    head_a;
  logic [IW-1:0]    tail_a;
  logic [IW-1:0]    head_b;
  logic [IW-1:0]    tail_b;
  logic             empty_a;
  logic             empty_b;

  logic [IW-1:0]    cur;
  logic [IW-1:0]    cur_next;
  logic [CNT_W-1:0] cnt;
  logic             dir_up;

  logic [1:0]       res_status;
  logic             res_mem;
  logic             res_last;

  logic [PW-1:0]    top_a;
  logic [PW-1:0]    top_b;
  logic             full;
  logic             we;
  logic             re;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    rd_addr;
  logic             fin_start;
  logic             fin_step;

  // one slot past A's tail and B's tail slot itself, queues meet when these coincide
  assign top_a = empty_a ? '0 : PW'(tail_a) + PW'(1);
  assign top_b = empty_b ? PW'(DEPTH) : PW'(tail_b);
  assign full  = (top_a == top_b);

  // list walk
  assign cur_next  = dir_up ? cur + IW'(1) : cur - IW'(1);
  assign fin_step  = (cur_next == (dir_up ? tail_a : tail_b)) ||
                     (cnt == CNT_W'(MAX_RESULTS - 2));
  assign fin_start = cmd.lst_a ? (head_a == tail_a) : (head_b == tail_b);

  // store addressing
  assign we      = cmd.ins_a || cmd.ins_b;
  assign wr_addr = cmd.ins_a ? (empty_a ? '0 : tail_a + IW'(1))
                             : (empty_b ? IW'(DEPTH - 1) : tail_b - IW'(1));
  assign re      = cmd.rem_a || cmd.rem_b || cmd.lst_a || cmd.lst_b || cmd.step;
  assign rd_addr = (cmd.rem_a || cmd.lst_a) ? head_a :
                   (cmd.rem_b || cmd.lst_b) ? head_b : cur_next;

  // entry store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= value_in;
    end
    if (re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_a <= 1'b1;
      empty_b <= 1'b1;
    end else begin
      if (cmd.ins_a) begin
        if (empty_a) begin
          head_a  <= '0;
          empty_a <= 1'b0;
        end
        tail_a <= wr_addr;
      end
      if (cmd.ins_b) begin
        if (empty_b) begin
          head_b  <= IW'(DEPTH - 1);
          empty_b <= 1'b0;
        end
        tail_b <= wr_addr;
      end
      if (cmd.rem_a) begin
        if (head_a == tail_a) begin
          empty_a <= 1'b1;
        end else begin
          head_a <= head_a + IW'(1);
        end
      end
      if (cmd.rem_b) begin
        if (head_b == tail_b) begin
          empty_b <= 1'b1;
        end else begin
          head_b <= head_b - IW'(1);
        end
      end
    end
  end

  // list cursor and result register
  always_ff @(posedge clk) begin
    if (cmd.lst_a || cmd.lst_b) begin
      cur    <= cmd.lst_a ? head_a : head_b;
      cnt    <= '0;
      dir_up <= cmd.lst_a;
    end else if (cmd.step) begin
      cur <= cur_next;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.load) begin
      res_status <= cmd.status;
      res_mem    <= cmd.mem;
      res_last   <= (cmd.lst_a || cmd.lst_b) ? fin_start : 1'b1;
    end else if (cmd.step) begin
      res_last <= fin_step;
    end
  end

  assign stat.empty_a = empty_a;
  assign stat.empty_b = empty_b;
  assign stat.full    = full;
  assign stat.last    = res_last;

  assign result.status    = res_status;
  assign result.value_out = res_mem ? rd_q : '0;
  assign result.last      = res_last;

endmodule

`default_nettype wire

FILE: sim/tb_two_queues_shared_buffer.sv
`default_nettype none

module tb_two_queues_shared_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import tqsb_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int ITEM_COUNT = 430;
  localparam int CALM_LO    = 150;
  localparam int CALM_HI    = 250;

  // kinds of random bursts
  typedef enum int {
    GEN_MIX,
    GEN_FILL,
    GEN_DRAIN,
    GEN_SCAN
  } burst_kind_t;

  typedef struct {
    in_item_t item;
    bit       drain_first;
    bit       calm;
  } op_entry_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // stimulus backlog and results still owed by the block
  op_entry_t op_backlog[$];
  out_item_t awaited_results[$];
  op_entry_t next_op;
  out_item_t want;
  bit        calm = 1'b0;
  int        errors = 0;

  // shadow of the two queues
  logic [DATA_W-1:0] slots[QDEPTH];
  int head_a = -1;
  int tail_a = -1;
  int head_b = QDEPTH;
  int tail_b = QDEPTH;

  two_queues_shared_buffer #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_v,
                                 input logic [DATA_W-1:0] got_v);
    if (errors < 50) begin
      $display("mismatch %s: want %h got %h at %0t", what, exp_v, got_v, $realtime);
    end
    errors++;
  endtask

  // update the shadow queues and queue up the results one operation owes
  function automatic void apply_queue_op(input in_item_t it);
    out_item_t r;
    int n;
    int i;
    r = '0;
    r.last = 1'b1;
    n = 0;
    case (it.opcode)
      OP_INS_A, OP_INS_B: begin
        if (tail_a == tail_b - 1) begin
          r.status = ST_OVF;
        end else if (it.opcode == OP_INS_A) begin
          if (tail_a == -1 && head_a == -1) begin
            head_a = 0;
            tail_a = 0;
          end else begin
            tail_a++;
          end
          slots[tail_a] = it.value_in;
        end else begin
          if (tail_b == QDEPTH && head_b == QDEPTH) begin
            head_b = QDEPTH - 1;
            tail_b = QDEPTH - 1;
          end else begin
            tail_b--;
          end
          slots[tail_b] = it.value_in;
        end
        awaited_results.push_back(r);
      end
      OP_REM_A: begin
        if (head_a == -1) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = slots[head_a];
          head_a++;
          if (head_a > tail_a) begin
            head_a = -1;
            tail_a = -1;
          end
        end
        awaited_results.push_back(r);
      end
      OP_REM_B: begin
        if (head_b == QDEPTH) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = slots[head_b];
          head_b--;
          if (head_b < tail_b) begin
            head_b = QDEPTH;
            tail_b = QDEPTH;
          end
        end
        awaited_results.push_back(r);
      end
      OP_LST_A: begin
        if (head_a == -1) begin
          r.status = ST_EMPTY;
          awaited_results.push_back(r);
        end else begin
          for (i = head_a; i <= tail_a && n < MAX_RESULTS; i++) begin
            r.value_out = slots[i];
            r.last = (i == tail_a) || (n == MAX_RESULTS - 1);
            awaited_results.push_back(r);
            n++;
          end
        end
      end
      OP_LST_B: begin
        if (head_b == QDEPTH) begin
          r.status = ST_EMPTY;
          awaited_results.push_back(r);
        end else begin
          for (i = head_b; i >= tail_b && n < MAX_RESULTS; i--) begin
            r.value_out = slots[i];
            r.last = (i == tail_b) || (n == MAX_RESULTS - 1);
            awaited_results.push_back(r);
            n++;
          end
        end
      end
      default: begin
        // unused opcodes are dropped by the block
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input logic [2:0] op, input logic [DATA_W-1:0] v,
                        input bit drain, input bit quiet);
    op_entry_t e;
    e.item.opcode   = op;
    e.item.value_in = v;
    e.drain_first   = drain;
    e.calm          = quiet;
    op_backlog.push_back(e);
  endtask

  // input driver, predicts at each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_queue_op(in_data);
      end
      if (!in_valid || in_ready) begin
        if (op_backlog.size() != 0 &&
            (!op_backlog[0].drain_first || awaited_results.size() == 0) &&
            (op_backlog[0].calm || $urandom_range(99) >= 25)) begin
          next_op = op_backlog.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_op.item;
          calm     <= next_op.calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor, checks each result transfer against the oldest owed one
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data.value_out);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch("status", DATA_W'(want.status), DATA_W'(out_data.status));
          end
          if (out_data.value_out !== want.value_out) begin
            report_mismatch("value_out", want.value_out, out_data.value_out);
          end
          if (out_data.last !== want.last) begin
            report_mismatch("last", DATA_W'(want.last), DATA_W'(out_data.last));
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // stimulus, reset and end of run
  initial begin
    int counted;
    int r;
    int k;
    int len;
    bit side;
    bit drain;
    bit quiet;
    logic [2:0] op;
    burst_kind_t kind;

    // empty queues, dropped opcodes, extreme values, drain and slot reuse
    add_op(OP_REM_A, rand_value(), 1'b0, 1'b0);
    add_op(OP_REM_B, rand_value(), 1'b0, 1'b0);
    add_op(OP_LST_A, rand_value(), 1'b0, 1'b0);
    add_op(OP_LST_B, rand_value(), 1'b0, 1'b0);
    add_op(3'd6, $urandom, 1'b0, 1'b0);
    add_op(3'd7, $urandom, 1'b0, 1'b0);
    add_op(OP_INS_A, 32'h7fff_ffff, 1'b0, 1'b0);
    add_op(OP_INS_A, 32'h8000_0000, 1'b0, 1'b0);
    add_op(OP_INS_B, 32'h0000_0000, 1'b0, 1'b0);
    add_op(OP_INS_B, 32'hffff_ffff, 1'b0, 1'b0);
    add_op(OP_LST_A, rand_value(), 1'b0, 1'b0);
    add_op(OP_LST_B, rand_value(), 1'b0, 1'b0);
    add_op(OP_REM_A, rand_value(), 1'b0, 1'b0);
    add_op(OP_LST_A, rand_value(), 1'b0, 1'b0);
    add_op(OP_REM_A, rand_value(), 1'b0, 1'b0);
    add_op(OP_INS_A, 32'h0000_0001, 1'b0, 1'b0);
    add_op(OP_REM_B, rand_value(), 1'b0, 1'b0);
    add_op(OP_REM_B, rand_value(), 1'b0, 1'b0);
    add_op(OP_REM_B, rand_value(), 1'b0, 1'b0);
    add_op(OP_REM_A, rand_value(), 1'b0, 1'b0);

    // random bursts of fills, drains, scans and mixed traffic
    counted = 0;
    drain = 1'b1;
    while (counted < ITEM_COUNT) begin
      kind = burst_kind_t'($urandom_range(3));
      side = 1'($urandom_range(1));
      case (kind)
        GEN_MIX:   len = $urandom_range(30, 15);
        GEN_FILL:  len = $urandom_range(22, 16);
        GEN_DRAIN: len = $urandom_range(18, 10);
        default:   len = $urandom_range(12, 6);
      endcase
      for (k = 0; k < len; k++) begin
        r = $urandom_range(99);
        case (kind)
          GEN_MIX: begin
            if (r < 3)       op = 3'($urandom_range(7, 6));
            else if (r < 43) op = $urandom_range(1) ? OP_INS_B : OP_INS_A;
            else if (r < 73) op = $urandom_range(1) ? OP_REM_B : OP_REM_A;
            else             op = $urandom_range(1) ? OP_LST_B : OP_LST_A;
          end
          GEN_FILL: begin
            if (r < 85)      op = $urandom_range(1) ? OP_INS_B : OP_INS_A;
            else if (r < 95) op = $urandom_range(1) ? OP_LST_B : OP_LST_A;
            else             op = $urandom_range(1) ? OP_REM_B : OP_REM_A;
          end
          GEN_DRAIN: begin
            if (r < 80)      op = side ? OP_REM_B : OP_REM_A;
            else if (r < 90) op = side ? OP_LST_B : OP_LST_A;
            else             op = side ? OP_INS_A : OP_INS_B;
          end
          default: begin
            if (r < 50)      op = $urandom_range(1) ? OP_LST_B : OP_LST_A;
            else if (r < 80) op = $urandom_range(1) ? OP_INS_B : OP_INS_A;
            else             op = $urandom_range(1) ? OP_REM_B : OP_REM_A;
          end
        endcase
        quiet = (counted >= CALM_LO) && (counted < CALM_HI);
        add_op(op, rand_value(), drain, quiet);
        drain = 1'b0;
        if (op <= OP_LST_B) begin
          counted++;
        end
      end
      drain = ($urandom_range(99) < 15);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // wait for every transfer and every owed result, then a quiet tail
    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2 * MAX_RESULTS + 4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      report_mismatch("results never delivered", '0, DATA_W'(awaited_results.size()));
    end

    if (errors == 0) begin
      $display("** two_queues_shared_buffer: PASSED **");
    end else begin
      $display("** two_queues_shared_buffer: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("** two_queues_shared_buffer: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
